// ----- sv/pvmg_pkg.sv -----
// shared types and constants for the packed voxel marker grid
// request and result beats, request codes, controller/datapath command and status
// no dependencies
`timescale 1ns / 1ps

package pvmg_pkg;

	localparam int COORD_W = 5;
	localparam int VAL_W   = 2;

	typedef enum logic [1:0] {
		REQ_READ  = 2'd0,
		REQ_WRITE = 2'd1,
		REQ_MARK  = 2'd2,
		REQ_QUERY = 2'd3
	} req_kind_t;

	typedef struct packed {
		req_kind_t          req_type;
		logic [COORD_W-1:0] x_lo;
		logic [COORD_W-1:0] y_lo;
		logic [COORD_W-1:0] z_lo;
		logic [COORD_W-1:0] x_hi;
		logic [COORD_W-1:0] y_hi;
		logic [COORD_W-1:0] z_hi;
		logic [VAL_W-1:0]   mark_value;
	} req_t;

	typedef struct packed {
		logic [VAL_W-1:0] cell_value;
		logic             box_hit;
	} rsp_t;

	typedef struct packed {
		logic clr_wr;
		logic load;
		logic row_wr;
		logic cap_cell;
		logic set_hit;
		logic step;
		logic out_load;
	} pvmg_cmd_t;

	typedef struct packed {
		logic      clr_last;
		req_kind_t kind;
		logic      in_grid;
		logic      empty;
		logic      last_row;
		logic      row_hit;
	} pvmg_sts_t;

endpackage

// ----- sv/pvmg_dp.sv -----
// datapath of the packed voxel marker grid: request registers, row memory,
// row modify logic, box row counters and result registers
// depends on pvmg_pkg
`timescale 1ns / 1ps

module pvmg_dp #(
	parameter int GRID_SIDE = 16,
	parameter int CELL_BITS = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  pvmg_pkg::pvmg_cmd_t cmd,
	output pvmg_pkg::pvmg_sts_t sts,
	input  pvmg_pkg::req_t      req,
	output pvmg_pkg::rsp_t      rsp
);

	localparam int IW     = (GRID_SIDE > 1) ? $clog2(GRID_SIDE) : 1;
	localparam int AW     = 2 * IW;
	localparam int DEPTH  = 1 << AW;
	localparam int ROW_W  = GRID_SIDE * CELL_BITS;
	localparam int SIDE_W = $clog2(GRID_SIDE + 1);
	localparam int CMP_W  = (SIDE_W > pvmg_pkg::COORD_W) ? SIDE_W : pvmg_pkg::COORD_W;
	localparam logic [CMP_W-1:0] SIDE = CMP_W'(GRID_SIDE);
	localparam logic [CMP_W-1:0] ONE  = CMP_W'(1);

	function automatic logic [CMP_W-1:0] clip_hi(input logic [pvmg_pkg::COORD_W-1:0] v);
		logic [CMP_W-1:0] e;
		e = CMP_W'(v);
		return (e > SIDE) ? SIDE : e;
	endfunction

	pvmg_pkg::req_kind_t  kind_q;
	logic [CMP_W-1:0]     xl_q, yl_q, zl_q, xh_q, yh_q, zh_q;
	logic [CELL_BITS-1:0] val_q;
	logic [IW-1:0]        y_q, z_q;
	logic [AW-1:0]        clr_q;
	logic [ROW_W-1:0]     grid_q [DEPTH];
	logic [ROW_W-1:0]     rd_q;
	logic [CELL_BITS-1:0] cell_res_q;
	logic                 hit_q;
	pvmg_pkg::rsp_t       rsp_q;

	logic [GRID_SIDE-1:0] lane_in;
	logic [GRID_SIDE-1:0] lane_pt;
	logic [ROW_W-1:0]     new_row;
	logic                 row_hit;
	logic                 mem_we;
	logic [AW-1:0]        wr_addr;
	logic [AW-1:0]        rd_addr;
	logic [ROW_W-1:0]     wr_data;
	logic                 y_wrap;
	logic [IW-1:0]        xi;

	always_comb begin
		for (int i = 0; i < GRID_SIDE; i++) begin
			lane_in[i] = (CMP_W'(i) >= xl_q) && (CMP_W'(i) < xh_q);
			lane_pt[i] = (CMP_W'(i) == xl_q);
		end
	end

	// one row of cells, modified lane by lane, and the hit test over the box lanes
	always_comb begin
		new_row = rd_q;
		row_hit = 1'b0;
		for (int i = 0; i < GRID_SIDE; i++) begin
			unique case (kind_q)
				pvmg_pkg::REQ_WRITE: begin
					if (lane_pt[i]) new_row[i*CELL_BITS +: CELL_BITS] = val_q;
				end
				pvmg_pkg::REQ_MARK: begin
					if (lane_in[i])
						new_row[i*CELL_BITS +: CELL_BITS] = rd_q[i*CELL_BITS +: CELL_BITS] | val_q;
				end
				default: ;
			endcase
			row_hit = row_hit | (lane_in[i] && (|(rd_q[i*CELL_BITS +: CELL_BITS] & val_q)));
		end
	end

	assign xi      = xl_q[IW-1:0];
	assign y_wrap  = (CMP_W'(y_q) + ONE) == yh_q;
	assign mem_we  = cmd.clr_wr | cmd.row_wr;
	assign wr_addr = cmd.clr_wr ? clr_q : {z_q, y_q};
	assign rd_addr = {z_q, y_q};
	assign wr_data = cmd.clr_wr ? '0 : new_row;

	always_ff @(posedge clk) begin
		if (mem_we) grid_q[wr_addr] <= wr_data;
		rd_q <= grid_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_wr) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q     <= req.req_type;
			xl_q       <= CMP_W'(req.x_lo);
			yl_q       <= CMP_W'(req.y_lo);
			zl_q       <= CMP_W'(req.z_lo);
			xh_q       <= clip_hi(req.x_hi);
			yh_q       <= clip_hi(req.y_hi);
			zh_q       <= clip_hi(req.z_hi);
			val_q      <= CELL_BITS'(req.mark_value);
			y_q        <= req.y_lo[IW-1:0];
			z_q        <= req.z_lo[IW-1:0];
			cell_res_q <= '0;
			hit_q      <= 1'b0;
		end else begin
			if (cmd.step) begin
				if (y_wrap) begin
					y_q <= yl_q[IW-1:0];
					z_q <= z_q + 1'b1;
				end else begin
					y_q <= y_q + 1'b1;
				end
			end
			if (cmd.cap_cell) cell_res_q <= rd_q[xi*CELL_BITS +: CELL_BITS];
			if (cmd.set_hit) hit_q <= 1'b1;
		end
		if (cmd.out_load) begin
			rsp_q.cell_value <= pvmg_pkg::VAL_W'(cell_res_q);
			rsp_q.box_hit    <= hit_q;
		end
	end

	assign sts.clr_last = &clr_q;
	assign sts.kind     = kind_q;
	assign sts.in_grid  = (xl_q < SIDE) && (yl_q < SIDE) && (zl_q < SIDE);
	assign sts.empty    = !((xl_q < xh_q) && (yl_q < yh_q) && (zl_q < zh_q));
	assign sts.last_row = y_wrap && ((CMP_W'(z_q) + ONE) == zh_q);
	assign sts.row_hit  = row_hit;

	assign rsp = rsp_q;

endmodule

// ----- sv/pvmg_ctrl.sv -----
// controller of the packed voxel marker grid: clearing sweep, request sequencing
// over box rows, and the result beat valid register
// depends on pvmg_pkg
`timescale 1ns / 1ps

module pvmg_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output pvmg_pkg::pvmg_cmd_t cmd,
	input  pvmg_pkg::pvmg_sts_t sts
);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_READ,
		S_MOD,
		S_DONE
	} state_t;

	state_t state_q;
	logic   rsp_valid_q;
	logic   is_box;

	assign is_box = (sts.kind == pvmg_pkg::REQ_MARK) || (sts.kind == pvmg_pkg::REQ_QUERY);

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_CLEAR: cmd.clr_wr = 1'b1;
			S_IDLE:  cmd.load = req_valid;
			S_MOD: begin
				cmd.row_wr   = ((sts.kind == pvmg_pkg::REQ_WRITE) && sts.in_grid) ||
				               ((sts.kind == pvmg_pkg::REQ_MARK) && !sts.empty);
				cmd.cap_cell = (sts.kind == pvmg_pkg::REQ_READ) && sts.in_grid;
				cmd.set_hit  = (sts.kind == pvmg_pkg::REQ_QUERY) && !sts.empty && sts.row_hit;
				// a query stops at its first hit
				cmd.step     = is_box && !sts.empty && !sts.last_row && !cmd.set_hit;
			end
			S_DONE:  cmd.out_load = !rsp_valid_q || !rsp_stall;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			rsp_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_CLEAR: if (sts.clr_last) state_q <= S_IDLE;
				S_IDLE:  if (req_valid) state_q <= S_READ;
				S_READ:  state_q <= S_MOD;
				S_MOD:   state_q <= cmd.step ? S_READ : S_DONE;
				S_DONE:  if (cmd.out_load) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
			if (cmd.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;

	a_accept_reads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && req_valid) |=> (state_q == S_READ))
		else $error("accepted request did not start a row read");

	a_mod_next: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MOD) |=> (state_q == S_READ || state_q == S_DONE))
		else $error("row modify left to an unexpected state");

	a_out_held: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && rsp_valid_q && rsp_stall) |=> (state_q == S_DONE && rsp_valid_q))
		else $error("pending result overwritten while output stalled");

	a_valid_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> ($past(state_q) == S_DONE))
		else $error("result beat raised outside done state");

	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> !rsp_valid_q)
		else $error("result beat during clearing sweep");

endmodule

// ----- sv/packed_voxel_marker_grid_core.sv -----
// top level of the packed voxel marker grid
// depends on pvmg_pkg, pvmg_ctrl and pvmg_dp
`timescale 1ns / 1ps

// The grid is held as one memory row per (z, y) pair, each row packing the
// GRID_SIDE cells along x. After reset the block sweeps all
// 2^(2*ceil(log2 GRID_SIDE)) memory rows to zero (256 at the default side
// of 16), one row a cycle, and holds req_stall high meanwhile. Each request
// is a read-modify-write over the row memory, which has separate read and
// write addresses and a registered read: a cell read or write steps through
// the read, modify and done states once, a box mark or query repeats the
// read and modify states for every row of the clipped box (an empty box runs
// them once), and a query ends at the first row that hits. The result beat
// sits in an output register, so a new request is accepted while the previous result waits on rsp_stall.
module packed_voxel_marker_grid_core #(
	parameter int GRID_SIDE = 16,
	parameter int CELL_BITS = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  pvmg_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output pvmg_pkg::rsp_t rsp
);

	pvmg_pkg::pvmg_cmd_t cmd;
	pvmg_pkg::pvmg_sts_t sts;

	pvmg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	pvmg_dp #(
		.GRID_SIDE (GRID_SIDE),
		.CELL_BITS (CELL_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sts    (sts),
		.req    (req),
		.rsp    (rsp)
	);

endmodule

// ----- bench/pvmg_grid_checker.sv -----
// watches the request and result beats of the voxel grid core, keeps its own copy of the
// grid, works out each result at request acceptance and compares the result beats in order
// depends on pvmg_pkg
`timescale 1ns / 1ps

module pvmg_grid_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	input  logic           req_stall,
	input  pvmg_pkg::req_t req,
	input  logic           rsp_valid,
	input  logic           rsp_stall,
	input  pvmg_pkg::rsp_t rsp,
	output int             mismatches,
	output int             pending
);

	localparam int SIDE  = 16;
	localparam int CELLS = SIDE * SIDE * SIDE;

	logic [pvmg_pkg::VAL_W-1:0] grid [CELLS];
	pvmg_pkg::rsp_t             awaited_rsp [$];

	function automatic int cell_addr(int x, int y, int z);
		return x + SIDE * (y + SIDE * z);
	endfunction

	function automatic int clip_bound(logic [pvmg_pkg::COORD_W-1:0] b);
		return (b > SIDE) ? SIDE : int'(b);
	endfunction

	// applies one request to the grid copy and returns the result it should give
	function automatic pvmg_pkg::rsp_t apply_request(pvmg_pkg::req_t r);
		pvmg_pkg::rsp_t res;
		int             xh, yh, zh, a;
		bit             in_grid;
		res     = '0;
		xh      = clip_bound(r.x_hi);
		yh      = clip_bound(r.y_hi);
		zh      = clip_bound(r.z_hi);
		in_grid = r.x_lo < SIDE && r.y_lo < SIDE && r.z_lo < SIDE;
		unique case (r.req_type)
			pvmg_pkg::REQ_READ: begin
				if (in_grid)
					res.cell_value = grid[cell_addr(r.x_lo, r.y_lo, r.z_lo)];
			end
			pvmg_pkg::REQ_WRITE: begin
				if (in_grid)
					grid[cell_addr(r.x_lo, r.y_lo, r.z_lo)] = r.mark_value;
			end
			default: begin
				// an empty box on any axis touches no cell
				for (int z = r.z_lo; z < zh; z++)
					for (int y = r.y_lo; y < yh; y++)
						for (int x = r.x_lo; x < xh; x++) begin
							a = cell_addr(x, y, z);
							if (r.req_type == pvmg_pkg::REQ_MARK)
								grid[a] = grid[a] | r.mark_value;
							else if ((grid[a] & r.mark_value) != '0)
								res.box_hit = 1'b1;
						end
			end
		endcase
		return res;
	endfunction

	task automatic report_mismatch(string msg);
		mismatches++;
		$display("[%0t] grid check: %s", $time, msg);
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		pvmg_pkg::rsp_t want;
		pvmg_pkg::rsp_t next_rsp;
		if (!arst_n) begin
			foreach (grid[i])
				grid[i] = '0;
			awaited_rsp.delete();
			mismatches = 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (awaited_rsp.size() == 0) begin
					report_mismatch($sformatf("result beat with none awaited: cell %0d hit %0d",
						rsp.cell_value, rsp.box_hit));
				end else begin
					want = awaited_rsp.pop_front();
					if (rsp.cell_value !== want.cell_value)
						report_mismatch($sformatf("cell_value got %0d want %0d",
							rsp.cell_value, want.cell_value));
					if (rsp.box_hit !== want.box_hit)
						report_mismatch($sformatf("box_hit got %0d want %0d",
							rsp.box_hit, want.box_hit));
				end
			end
			if (req_valid && !req_stall) begin
				next_rsp    = apply_request(req);
				awaited_rsp = {awaited_rsp, next_rsp};
			end
		end
		pending = awaited_rsp.size();
	end

endmodule

// ----- bench/tb_packed_voxel_marker_grid_core.sv -----
// testbench top for the packed voxel marker grid core: clock, reset, request and result
// stall drivers, directed and random requests, watchdog and verdict
// depends on pvmg_pkg, packed_voxel_marker_grid_core and pvmg_grid_checker
`timescale 1ns / 1ps

module tb_packed_voxel_marker_grid_core;

	localparam int RANDOM_ITEMS = 926;
	localparam int IDLE_LIMIT   = 4000;
	localparam int HOLD_AT_BEAT = 400;
	localparam int HOLD_CYCLES  = 250;

	logic           clk;
	logic           arst_n;
	logic           req_valid;
	logic           req_stall;
	pvmg_pkg::req_t req;
	logic           rsp_valid;
	logic           rsp_stall;
	pvmg_pkg::rsp_t rsp;
	int             mismatches;
	int             pending;
	int             sent;

	packed_voxel_marker_grid_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	pvmg_grid_checker grid_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp),
		.mismatches (mismatches),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic pvmg_pkg::req_t make_req(pvmg_pkg::req_kind_t kind, int xl, int yl,
		int zl, int xh, int yh, int zh, int mv);
		pvmg_pkg::req_t r;
		r.req_type   = kind;
		r.x_lo       = pvmg_pkg::COORD_W'(xl);
		r.y_lo       = pvmg_pkg::COORD_W'(yl);
		r.z_lo       = pvmg_pkg::COORD_W'(zl);
		r.x_hi       = pvmg_pkg::COORD_W'(xh);
		r.y_hi       = pvmg_pkg::COORD_W'(yh);
		r.z_hi       = pvmg_pkg::COORD_W'(zh);
		r.mark_value = pvmg_pkg::VAL_W'(mv);
		return r;
	endfunction

	// mostly a dense corner so reads and queries meet marked cells
	function automatic int pick_coord();
		int p;
		p = $urandom_range(0, 99);
		if (p < 80)
			return $urandom_range(0, 7);
		if (p < 92)
			return $urandom_range(8, 15);
		return $urandom_range(16, 31);
	endfunction

	// small boxes most of the time, sometimes any bound (empty, clipped or wide)
	function automatic int pick_upper(int lo);
		int p, hi;
		p = $urandom_range(0, 99);
		if (p < 85) begin
			hi = lo + $urandom_range(0, 4);
			return (hi > 31) ? 31 : hi;
		end
		return $urandom_range(0, 31);
	endfunction

	function automatic pvmg_pkg::req_t random_req();
		int                  p, xl, yl, zl, mv;
		pvmg_pkg::req_kind_t kind;
		p    = $urandom_range(0, 99);
		kind = (p < 30) ? pvmg_pkg::REQ_READ : (p < 55) ? pvmg_pkg::REQ_WRITE :
		       (p < 75) ? pvmg_pkg::REQ_MARK : pvmg_pkg::REQ_QUERY;
		xl   = pick_coord();
		yl   = pick_coord();
		zl   = pick_coord();
		mv   = $urandom_range(0, 3);
		if (kind == pvmg_pkg::REQ_READ || kind == pvmg_pkg::REQ_WRITE)
			return make_req(kind, xl, yl, zl, $urandom_range(0, 31), $urandom_range(0, 31),
				$urandom_range(0, 31), mv);
		return make_req(kind, xl, yl, zl, pick_upper(xl), pick_upper(yl), pick_upper(zl), mv);
	endfunction

	// called at a falling edge, returns at the falling edge after the beat is taken
	task automatic send_req(pvmg_pkg::req_t r);
		int gap;
		// every fourth run of 60 beats goes back to back
		gap = ((sent / 60) % 4 == 3) ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_valid <= 1'b1;
		req       <= r;
		do
			@(posedge clk);
		while (!(req_valid && !req_stall));
		sent++;
		@(negedge clk);
	endtask

	// result side: random stall per beat, calm runs, and one long hold-off
	initial begin : rsp_side
		int beats, n, calm_left;
		beats     = 0;
		calm_left = 0;
		rsp_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (beats == HOLD_AT_BEAT) begin
				n = HOLD_CYCLES;
			end else if (calm_left > 0) begin
				n = 0;
				calm_left--;
			end else begin
				n = $urandom_range(0, 5);
				if ($urandom_range(0, 19) == 0)
					calm_left = 30;
			end
			if (n > 0) begin
				rsp_stall <= 1'b1;
				repeat (n) @(negedge clk);
			end
			rsp_stall <= 1'b0;
			do
				@(posedge clk);
			while (!(rsp_valid && !rsp_stall));
			beats++;
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < IDLE_LIMIT) begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("end of test: mismatches");
		$finish;
	end

	initial begin : stimulus
		arst_n    = 1'b0;
		req_valid = 1'b0;
		req       = '0;
		sent      = 0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// single cells at the corners, outside the grid, unused fields set
		send_req(make_req(pvmg_pkg::REQ_READ, 0, 0, 0, 0, 0, 0, 3));
		send_req(make_req(pvmg_pkg::REQ_WRITE, 15, 15, 15, 31, 31, 31, 3));
		send_req(make_req(pvmg_pkg::REQ_READ, 15, 15, 15, 0, 0, 0, 0));
		send_req(make_req(pvmg_pkg::REQ_WRITE, 16, 3, 3, 0, 0, 0, 1));
		send_req(make_req(pvmg_pkg::REQ_READ, 16, 3, 3, 0, 0, 0, 0));
		send_req(make_req(pvmg_pkg::REQ_READ, 0, 4, 3, 0, 0, 0, 0));
		send_req(make_req(pvmg_pkg::REQ_READ, 31, 31, 31, 31, 31, 31, 3));
		send_req(make_req(pvmg_pkg::REQ_WRITE, 0, 0, 0, 31, 31, 31, 2));
		// mark keeps each cell's own bits
		send_req(make_req(pvmg_pkg::REQ_MARK, 0, 0, 0, 2, 2, 2, 1));
		send_req(make_req(pvmg_pkg::REQ_READ, 0, 0, 0, 0, 0, 0, 0));
		send_req(make_req(pvmg_pkg::REQ_READ, 1, 1, 1, 0, 0, 0, 0));
		send_req(make_req(pvmg_pkg::REQ_READ, 2, 0, 0, 0, 0, 0, 0));
		// empty boxes
		send_req(make_req(pvmg_pkg::REQ_QUERY, 4, 4, 4, 4, 4, 4, 3));
		send_req(make_req(pvmg_pkg::REQ_QUERY, 5, 0, 0, 3, 16, 16, 3));
		send_req(make_req(pvmg_pkg::REQ_MARK, 16, 0, 0, 31, 31, 31, 3));
		// upper bounds clipped to the grid
		send_req(make_req(pvmg_pkg::REQ_MARK, 14, 14, 14, 31, 31, 31, 2));
		send_req(make_req(pvmg_pkg::REQ_READ, 15, 15, 15, 0, 0, 0, 0));
		send_req(make_req(pvmg_pkg::REQ_READ, 14, 14, 14, 0, 0, 0, 0));
		send_req(make_req(pvmg_pkg::REQ_QUERY, 14, 14, 14, 16, 16, 16, 1));
		send_req(make_req(pvmg_pkg::REQ_QUERY, 14, 14, 14, 15, 15, 15, 1));
		// whole grid sweeps
		send_req(make_req(pvmg_pkg::REQ_QUERY, 0, 0, 0, 31, 31, 31, 0));
		send_req(make_req(pvmg_pkg::REQ_QUERY, 0, 0, 0, 31, 31, 31, 2));
		send_req(make_req(pvmg_pkg::REQ_MARK, 0, 0, 0, 16, 16, 16, 0));
		send_req(make_req(pvmg_pkg::REQ_WRITE, 1, 1, 1, 0, 0, 0, 0));
		send_req(make_req(pvmg_pkg::REQ_QUERY, 0, 0, 0, 2, 2, 2, 2));

		for (int i = 0; i < RANDOM_ITEMS; i++)
			send_req(random_req());
		req_valid <= 1'b0;

		wait (pending == 0);
		repeat (20) @(negedge clk);
		if (mismatches == 0 && pending == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// ----- files.f -----
sv/pvmg_pkg.sv
sv/pvmg_dp.sv
sv/pvmg_ctrl.sv
sv/packed_voxel_marker_grid_core.sv
bench/pvmg_grid_checker.sv
bench/tb_packed_voxel_marker_grid_core.sv
